### src/html_escape_word_breaker_defines.svh
// Assertion macros used by the checker file of the HTML escape word breaker.
`ifndef HTML_ESCAPE_WORD_BREAKER_DEFINES_SVH
`define HTML_ESCAPE_WORD_BREAKER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define HWB_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("html escape word breaker check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define HWB_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("html escape word breaker check failed");

`endif

### src/hwb_pkg.sv
// Shared types and constants of the HTML escape word breaker.
`timescale 1ns / 1ps
`default_nettype none

package hwb_pkg;

	// Kinds of output token.
	typedef enum logic [2:0] {
		TK_LIT   = 3'd0,
		TK_BR    = 3'd1,
		TK_NBSP4 = 3'd2,
		TK_QUOT  = 3'd3,
		TK_LT    = 3'd4,
		TK_GT    = 3'd5,
		TK_END   = 3'd6
	} token_kind_t;

	// Input request: one text byte or the end marker.
	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_text;
	} text_req_t;

	// Output request: one HTML token.
	typedef struct packed {
		token_kind_t token_kind;
		logic [7:0]  byte_value;
		logic [15:0] repeat_count;
		logic        last_of_item;
	} token_req_t;

	// Work entry passed from the front to the back through the queue.
	typedef struct packed {
		logic       is_end;
		logic [7:0] char_byte;
		logic       no_break_char;
		logic       item_end;
	} work_t;

	// Configuration register contents.
	typedef struct packed {
		logic [15:0] max_run;
		logic        add_markups;
	} cfg_t;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned PADDR_W     = 3;

	// Register indexes, taken from paddr[2].
	localparam logic REG_MAX_RUN     = 1'b0;
	localparam logic REG_ADD_MARKUPS = 1'b1;

	// Character codes.
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_QUOT  = 8'h22;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;

	// Space, line feed and tab all give a natural place to break a line.
	function automatic logic is_break_char(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB);
	endfunction

endpackage

`default_nettype wire

### src/hwb_front.sv
// Front part: lookahead delay line that turns text bytes into work entries.
`timescale 1ns / 1ps
`default_nettype none

module hwb_front
	import hwb_pkg::*;
#(
	parameter int unsigned LOOKAHEAD = 4
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             text_valid,
	output logic            text_ready,
	input  wire text_req_t  text,
	input  wire             q_full,
	output logic            push,
	output work_t           push_data
);

	localparam int unsigned HW = $clog2(LOOKAHEAD + 1);
	localparam logic [HW-1:0] FULL = HW'(LOOKAHEAD);

	logic [7:0]         la_q [LOOKAHEAD];
	logic [HW-1:0]      held_q;
	logic               drain_q;
	logic               accept;
	logic               byte_in;
	logic               shift;
	logic [HW-1:0]      wr_idx;
	logic [LOOKAHEAD-1:0] brk_vec;

	// New requests are taken unless the held bytes are being flushed or the queue is full.
	assign text_ready = !drain_q && !q_full;
	assign accept     = text_valid && text_ready;
	assign byte_in    = accept && !text.end_of_text;

	// Break characters among the held bytes.
	always_comb begin
		for (int i = 0; i < LOOKAHEAD; i++) begin
			brk_vec[i] = (HW'(i) < held_q) && is_break_char(la_q[i]);
		end
	end

	// Work entry generation, one per cycle at most.
	always_comb begin
		push      = 1'b0;
		push_data = '{is_end: 1'b0, char_byte: la_q[0], no_break_char: !(|brk_vec),
			item_end: 1'b0};
		shift     = 1'b0;
		if (drain_q) begin
			if (!q_full) begin
				push = 1'b1;
				if (held_q != '0) begin
					shift = 1'b1;
				end else begin
					push_data = '{is_end: 1'b1, char_byte: 8'h00, no_break_char: 1'b1,
						item_end: 1'b1};
				end
			end
		end else if (byte_in && (held_q == FULL)) begin
			push = 1'b1;
			shift = 1'b1;
			push_data.no_break_char = !((|brk_vec) || is_break_char(text.char_byte));
			push_data.item_end = 1'b1;
		end
	end

	// Once the line is full, the new byte enters at its tail after the shift.
	assign wr_idx = (held_q == FULL) ? FULL - HW'(1) : held_q;

	// Fill count and flush control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			drain_q <= 1'b0;
		end else if (drain_q) begin
			if (!q_full) begin
				if (held_q != '0) begin
					held_q <= held_q - HW'(1);
				end else begin
					drain_q <= 1'b0;
				end
			end
		end else if (accept) begin
			if (text.end_of_text) begin
				drain_q <= 1'b1;
			end else if (held_q != FULL) begin
				held_q <= held_q + HW'(1);
			end
		end
	end

	// Delay line storage.
	always_ff @(posedge clk) begin
		if (shift) begin
			for (int i = 0; i < LOOKAHEAD - 1; i++) begin
				la_q[i] <= la_q[i + 1];
			end
		end
		if (byte_in) begin
			for (int i = 0; i < LOOKAHEAD; i++) begin
				if (HW'(i) == wr_idx) begin
					la_q[i] <= text.char_byte;
				end
			end
		end
	end

endmodule

`default_nettype wire

### src/hwb_queue.sv
// Short queue of work entries between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module hwb_queue
	import hwb_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         push,
	input  wire work_t  push_data,
	output logic        full,
	input  wire         pop,
	output logic        valid,
	output work_t       head
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	work_t         ent_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign valid   = (cnt_q != '0);
	assign head    = ent_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

### src/hwb_back.sv
// Back part: escapes work entries, tracks space runs and inserts forced breaks.
`timescale 1ns / 1ps
`default_nettype none

module hwb_back
	import hwb_pkg::*;
#(
	parameter int unsigned COUNT_BITS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire cfg_t   cfg,
	input  wire         q_valid,
	input  wire work_t  q_data,
	output logic        q_pop,
	output logic        token_valid,
	input  wire         token_ready,
	output token_req_t  token
);

	localparam int unsigned PW = (COUNT_BITS < 16) ? COUNT_BITS : 16;
	localparam int unsigned CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	// Text state.
	logic [COUNT_BITS-1:0] run_q, run_nx, run_inc;
	logic [PW-1:0]         pend_q, pend_nx;
	logic                  seen_q, seen_nx;

	// Tokens of the current entry still to be sent: space run, token, newline.
	logic [2:0]  mask_q, mask_nx, mask_left, low_bit;
	logic [PW-1:0] sp_cnt_q;
	token_kind_t kind_q, kind_nx;
	logic [7:0]  tbyte_q, tbyte_nx;
	logic        item_end_q;

	logic        emit;
	logic        out_valid_q;
	token_req_t  out_q, tok_nx;
	logic [7:0]  c;

	assign token_valid = out_valid_q;
	assign token       = out_q;

	// Pick the next token of the current entry.
	assign low_bit   = mask_q & (~mask_q + 3'd1);
	assign emit      = (mask_q != 3'b000) && (!out_valid_q || token_ready);
	assign mask_left = emit ? (mask_q & ~low_bit) : mask_q;
	assign q_pop     = q_valid && (mask_left == 3'b000);

	always_comb begin
		if (low_bit[0]) begin
			tok_nx = '{token_kind: TK_LIT, byte_value: CH_SPACE,
				repeat_count: 16'(sp_cnt_q), last_of_item: 1'b0};
		end else if (low_bit[1]) begin
			tok_nx = '{token_kind: kind_q, byte_value: tbyte_q,
				repeat_count: 16'd1, last_of_item: 1'b0};
		end else begin
			tok_nx = '{token_kind: TK_LIT, byte_value: CH_LF,
				repeat_count: 16'd1, last_of_item: 1'b0};
		end
		tok_nx.last_of_item = item_end_q && (mask_left == 3'b000);
	end

	// Classify the entry at the head of the queue and work out the new state.
	assign c       = q_data.char_byte;
	assign run_inc = (run_q == '1) ? run_q : run_q + COUNT_BITS'(1);

	always_comb begin
		run_nx   = run_q;
		pend_nx  = pend_q;
		seen_nx  = seen_q;
		mask_nx  = 3'b000;
		kind_nx  = TK_LIT;
		tbyte_nx = c;
		if (q_data.is_end) begin
			run_nx   = '0;
			pend_nx  = '0;
			seen_nx  = 1'b0;
			mask_nx  = 3'b010;
			kind_nx  = TK_END;
			tbyte_nx = 8'h00;
		end else if (c == CH_SPACE) begin
			// Leading spaces are dropped; later ones extend the held run.
			if (seen_q) begin
				if (pend_q != '1) begin
					pend_nx = pend_q + PW'(1);
				end
				run_nx = '0;
			end
		end else begin
			seen_nx = 1'b1;
			if (c != CH_CR) begin
				mask_nx[0] = (pend_q != '0);
				mask_nx[1] = 1'b1;
				pend_nx    = '0;
				tbyte_nx   = 8'h00;
				if ((c == CH_LF) && cfg.add_markups) begin
					kind_nx = TK_BR;
					run_nx  = '0;
				end else if (c == CH_TAB) begin
					kind_nx = TK_NBSP4;
					run_nx  = '0;
				end else if (c == CH_QUOT) begin
					kind_nx = TK_QUOT;
					run_nx  = run_inc;
				end else if (c == CH_LT) begin
					kind_nx = TK_LT;
					run_nx  = run_inc;
				end else if (c == CH_GT) begin
					kind_nx = TK_GT;
					run_nx  = run_inc;
				end else begin
					kind_nx  = TK_LIT;
					tbyte_nx = c;
					run_nx   = run_inc;
				end
			end
			// Forced break when the run hits the limit and no break is near.
			if ((cfg.max_run != 16'd0) && (CW'(run_nx) == CW'(cfg.max_run)) &&
				q_data.no_break_char) begin
				mask_nx[2] = 1'b1;
				run_nx     = '0;
			end
		end
	end

	// Control and text state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= '0;
			pend_q      <= '0;
			seen_q      <= 1'b0;
			mask_q      <= 3'b000;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				run_q  <= run_nx;
				pend_q <= pend_nx;
				seen_q <= seen_nx;
				mask_q <= mask_nx;
			end else begin
				mask_q <= mask_left;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (token_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Entry payload and output register.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			sp_cnt_q   <= pend_q;
			kind_q     <= kind_nx;
			tbyte_q    <= tbyte_nx;
			item_end_q <= q_data.item_end;
		end
		if (emit) begin
			out_q <= tok_nx;
		end
	end

endmodule

`default_nettype wire

### src/html_escape_word_breaker.sv
// Top level of the HTML escape word breaker: configuration registers and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Turns a byte stream into HTML tokens. A request on the text channel is taken
// in any cycle in which the work queue between the lookahead front and the
// escaping back has room; the first LOOKAHEAD bytes of a text only fill the
// delay line. Each later byte sends zero to three tokens (held space run,
// escaped token, forced line break) through the single output register, one
// token per cycle while token_ready is high. An end marker flushes the held
// bytes one per cycle into the queue while it has room and blocks the text
// channel until the held bytes and the end entry are in the queue; the text
// then closes with an end token.
// max_run (address 0) and add_markups (address 4) are written over the APB
// port; the user must see that they are written only while the block is idle;
// the block itself does not enforce it.
module html_escape_word_breaker
	import hwb_pkg::*;
#(
	parameter int unsigned LOOKAHEAD  = 4,
	parameter int unsigned COUNT_BITS = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire [PADDR_W-1:0]  paddr,
	input  wire [31:0]         pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  wire                text_valid,
	output logic               text_ready,
	input  wire text_req_t     text,
	output logic               token_valid,
	input  wire                token_ready,
	output token_req_t         token
);

	cfg_t  cfg_q;
	logic  q_full;
	logic  q_valid;
	logic  push;
	logic  q_pop;
	work_t push_data;
	work_t q_head;

	assign pready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_run     <= 16'd0;
			cfg_q.add_markups <= 1'b1;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_MAX_RUN: begin
					cfg_q.max_run <= pwdata[15:0];
				end
				REG_ADD_MARKUPS: begin
					cfg_q.add_markups <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Register read back.
	always_comb begin
		case (paddr[2])
			REG_MAX_RUN: prdata = {16'd0, cfg_q.max_run};
			REG_ADD_MARKUPS: prdata = {31'd0, cfg_q.add_markups};
			default: prdata = 32'd0;
		endcase
	end

	hwb_front #(
		.LOOKAHEAD(LOOKAHEAD)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_valid(text_valid),
		.text_ready(text_ready),
		.text      (text),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	hwb_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	hwb_back #(
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (q_valid),
		.q_data     (q_head),
		.q_pop      (q_pop),
		.token_valid(token_valid),
		.token_ready(token_ready),
		.token      (token)
	);

endmodule

`default_nettype wire

### src/hwb_checker.sv
// Port-level checks of the HTML escape word breaker and their binding.
`timescale 1ns / 1ps
`default_nettype none
`include "html_escape_word_breaker_defines.svh"

module hwb_checker
	import hwb_pkg::*;
(
	input wire             clk,
	input wire             arst_n,
	input wire             token_valid,
	input wire             token_ready,
	input wire token_req_t token
);

	// A stalled token request keeps its payload.
	`HWB_ASSERT_NXT(a_token_hold, token_valid && !token_ready, token_valid && $stable(token))

	// Only literal tokens carry a byte value.
	`HWB_ASSERT_IMP(a_byte_only_literal, token_valid && (token.token_kind != TK_LIT), token.byte_value == 8'h00)

	// Only a space run repeats; every other token counts once.
	`HWB_ASSERT_IMP(a_repeat_spaces, token_valid && ((token.token_kind != TK_LIT) || (token.byte_value != CH_SPACE)), token.repeat_count == 16'd1)

	// The end token always closes its request.
	`HWB_ASSERT_IMP(a_end_is_last, token_valid && (token.token_kind == TK_END), token.last_of_item)

endmodule

bind html_escape_word_breaker hwb_checker u_hwb_checker (.*);

`default_nettype wire
